// File: sv/cdq_pkg.sv
// Shared types and constants for the circular deque block.
// No dependencies; cdq_dp, cdq_ctrl and circular_deque refer to it by scoped names.
package cdq_pkg;

  localparam int DEPTH_DFLT = 64;
  localparam int DATA_W     = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic    exec;        // carry out the accepted operation
    op_t     op;
    logic    ld_imm;      // load result with zero value and imm_status
    status_t imm_status;
    logic    ld_ram;      // load result from memory read data, status ok
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
  } sts_t;

endpackage

// File: sv/cdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/cdq_dp.sv
// Datapath of the circular deque: front/rear pointers, empty flag, entry store
// and result register. Depends on cdq_pkg and cdq_ram.
module cdq_dp #(
  parameter int DEPTH = cdq_pkg::DEPTH_DFLT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cdq_pkg::cmd_t              cmd,
  input  logic [cdq_pkg::DATA_W-1:0] push_value,
  output cdq_pkg::sts_t              sts,
  output logic [cdq_pkg::DATA_W-1:0] pop_value,
  output cdq_pkg::status_t           status
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic          full;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [cdq_pkg::DATA_W-1:0] rd_data;
  logic [cdq_pkg::DATA_W-1:0] pop_value_r;
  cdq_pkg::status_t           status_r;

  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST : head_r - 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST : tail_r - 1'b1;
  assign full     = !empty_r && (tail_inc == head_r);

  assign sts.empty = empty_r;
  assign sts.full  = full;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    if (cmd.exec) begin
      case (cmd.op)
        cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
          if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
            wr_en     = 1'b1;
            wr_addr   = '0;
          end else if (!full) begin
            wr_en = 1'b1;
            if (cmd.op == cdq_pkg::OP_PUSH_FRONT) begin
              head_nxt = head_dec;
              wr_addr  = head_dec;
            end else begin
              tail_nxt = tail_inc;
              wr_addr  = tail_inc;
            end
          end
        end
        default: begin
          if (!empty_r) begin
            rd_en   = 1'b1;
            rd_addr = (cmd.op == cdq_pkg::OP_POP_FRONT) ? head_r : tail_r;
            if (head_r == tail_r) begin
              // last element leaves: return to the reset arrangement
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (cmd.op == cdq_pkg::OP_POP_FRONT) begin
              head_nxt = head_inc;
            end else begin
              tail_nxt = tail_dec;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  cdq_ram #(
    .WIDTH (cdq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_imm) begin
      pop_value_r <= '0;
      status_r    <= cmd.imm_status;
    end else if (cmd.ld_ram) begin
      pop_value_r <= rd_data;
      status_r    <= cdq_pkg::ST_OK;
    end
  end

  assign pop_value = pop_value_r;
  assign status    = status_r;

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0) && (tail_r == '0))
    else $error("empty deque with pointers off zero");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && full && (cmd.op == cdq_pkg::OP_PUSH_FRONT || cmd.op == cdq_pkg::OP_PUSH_REAR)
    |=> $stable(head_r) && $stable(tail_r) && !empty_r)
    else $error("refused push changed the pointers");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && empty_r && (cmd.op == cdq_pkg::OP_POP_FRONT || cmd.op == cdq_pkg::OP_POP_REAR)
    |=> empty_r)
    else $error("refused pop left the empty state");

  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("memory written and read by the same operation");

endmodule

// File: sv/cdq_ctrl.sv
// Controller of the circular deque: handshakes, result valid and sequencing of
// the memory read for pops. Depends on cdq_pkg.
module cdq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_op,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  cdq_pkg::sts_t    sts,
  output cdq_pkg::cmd_t    cmd
);

  cdq_pkg::fsm_t state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          slot_free;
  cdq_pkg::op_t  op;

  assign op        = cdq_pkg::op_t'(in_op);
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    in_tready      = 1'b0;
    cmd.exec       = 1'b0;
    cmd.op         = op;
    cmd.ld_imm     = 1'b0;
    cmd.imm_status = cdq_pkg::ST_OK;
    cmd.ld_ram     = 1'b0;
    unique case (state_r)
      cdq_pkg::S_IDLE: begin
        in_tready = slot_free;
        if (in_tvalid && slot_free) begin
          cmd.exec = 1'b1;
          if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_POP_REAR) begin
            if (sts.empty) begin
              cmd.ld_imm     = 1'b1;
              cmd.imm_status = cdq_pkg::ST_EMPTY;
              out_valid_nxt  = 1'b1;
            end else begin
              state_nxt = cdq_pkg::S_READ;
            end
          end else begin
            cmd.ld_imm     = 1'b1;
            cmd.imm_status = sts.full ? cdq_pkg::ST_FULL : cdq_pkg::ST_OK;
            out_valid_nxt  = 1'b1;
          end
        end
      end
      cdq_pkg::S_READ: begin
        if (slot_free) begin
          cmd.ld_ram    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_read_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdq_pkg::S_READ) |-> !in_tready)
    else $error("input taken while a pop read is pending");

  a_pop_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !sts.empty && (cmd.op == cdq_pkg::OP_POP_FRONT || cmd.op == cdq_pkg::OP_POP_REAR)
    |=> (state_r == cdq_pkg::S_READ))
    else $error("successful pop did not wait for read data");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ld_imm && cmd.ld_ram))
    else $error("two result loads in one cycle");

endmodule

// File: sv/circular_deque.sv
// Top level of the circular deque: wires the controller to the datapath.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp (and cdq_ram through cdq_dp).
//
// Double-ended queue of signed 32-bit values held in a circular store of DEPTH
// entries. in_tuser selects the operation (0 push front, 1 push rear, 2 pop
// front, 3 pop rear) and in_tdata carries the value to push. Every input
// transaction yields exactly one output transaction: out_tdata is the popped
// value (zero for pushes and refused ops) and out_tuser the status (0 ok,
// 1 full and push refused, 2 empty and pop refused). A refused operation leaves
// the queue untouched. For pushes and refused operations the result loads the
// output register at the accepting edge and the next transaction can be taken
// in the following cycle. A successful pop waits in S_READ for the registered
// read of the entry memory, which then loads the result. The output register
// decouples the sides: input is taken while a result waits, provided the
// result is drained in that same cycle. No clearing pass runs after reset;
// the store is only ever read at occupied entries.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] pop_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  cdq_pkg::cmd_t    cmd;
  cdq_pkg::sts_t    sts;
  cdq_pkg::status_t status;

  // sequence each transaction and own both handshakes
  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // pointers, store and result payload
  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .push_value (in_tdata),
    .sts        (sts),
    .pop_value  (out_tdata),
    .status     (status)
  );

  assign out_tuser = 2'(status);

endmodule
